// ----- src/aar_pkg.sv -----
// Shared types, constants and helper functions for the steering-arc rollout block.
// No dependencies; imported by aar_cordic, aar_divider, ackermann_arc_rollout_top and the testbench.
package aar_pkg;

    typedef logic signed [33:0] ang_q30_t;
    typedef logic signed [31:0] trig_t;
    typedef logic signed [58:0] mul_prod_t;

    typedef enum logic [2:0] {
        CFG_CAND_COUNT = 3'd0,
        CFG_HORIZON    = 3'd1,
        CFG_SPEED      = 3'd2,
        CFG_TIME_STEP  = 3'd3,
        CFG_WHEELBASE  = 3'd4
    } cfg_index_t;

    localparam int DIV_NW = 64;
    localparam int DIV_DW = 40;

    localparam logic [13:0] STEER_LIMIT = 14'd5734;
    localparam logic [14:0] STEER_SPAN2 = 15'd22936;
    localparam logic [16:0] TWO_PI_Q14  = 17'd102944;
    localparam logic [16:0] PI_Q14      = 17'd51472;
    // floor(2^37 / TWO_PI_Q14), for the heading-rate wrap
    localparam logic [20:0] MOD_RECIP   = 21'd1335084;

    localparam ang_q30_t PI_Q30      = 34'sd3373259426;
    localparam ang_q30_t HALF_PI_Q30 = 34'sd1686629713;
    localparam ang_q30_t GAIN_Q30    = 34'sd652032875;

    // arctan(2^-i) in Q.30
    function automatic ang_q30_t atan_q30(input logic [4:0] i);
        ang_q30_t r;
        case (i)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048576;
            5'd11:   r = 34'sd524288;
            5'd12:   r = 34'sd262144;
            5'd13:   r = 34'sd131072;
            5'd14:   r = 34'sd65536;
            5'd15:   r = 34'sd32768;
            5'd16:   r = 34'sd16384;
            5'd17:   r = 34'sd8192;
            5'd18:   r = 34'sd4096;
            5'd19:   r = 34'sd2048;
            5'd20:   r = 34'sd1024;
            5'd21:   r = 34'sd512;
            5'd22:   r = 34'sd256;
            5'd23:   r = 34'sd128;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // product / 2^30, rounded half away from zero, wrapped to 32 bits
    function automatic logic signed [31:0] round_q30(input mul_prod_t p);
        logic [58:0] mag;
        logic [58:0] q;
        logic [31:0] r;
        mag = p[58] ? 59'(-p) : 59'(p);
        q   = (mag + 59'(1 << 29)) >> 30;
        r   = q[31:0];
        return p[58] ? $signed(-r) : $signed(r);
    endfunction

endpackage

// ----- src/aar_cordic.sv -----
// Iterative rotation-mode CORDIC giving cos and sin in Q.30, one micro-rotation a cycle.
// Depends on aar_pkg.
module aar_cordic #(
    parameter int ITERS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  aar_pkg::ang_q30_t angle,
    output logic              done,
    output aar_pkg::trig_t    cos_out,
    output aar_pkg::trig_t    sin_out
);
    import aar_pkg::*;

    localparam int CW = $clog2(ITERS);

    ang_q30_t        x_reg, y_reg, z_reg;
    ang_q30_t        x_next, y_next, z_next;
    logic            neg_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    ang_q30_t        fold;
    logic            fold_neg;

    always_comb
    begin
        fold_neg = 1'b0;
        fold     = angle;
        if (angle > HALF_PI_Q30)
        begin
            fold     = angle - PI_Q30;
            fold_neg = 1'b1;
        end
        else if (angle < -HALF_PI_Q30)
        begin
            fold     = angle + PI_Q30;
            fold_neg = 1'b1;
        end
    end

    always_comb
    begin
        if (!z_reg[33])
        begin
            x_next = x_reg - (y_reg >>> cnt_reg);
            y_next = y_reg + (x_reg >>> cnt_reg);
            z_next = z_reg - atan_q30(5'(cnt_reg));
        end
        else
        begin
            x_next = x_reg + (y_reg >>> cnt_reg);
            y_next = y_reg - (x_reg >>> cnt_reg);
            z_next = z_reg + atan_q30(5'(cnt_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= GAIN_Q30;
            y_reg   <= '0;
            z_reg   <= fold;
            neg_reg <= fold_neg;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done    = done_reg;
    assign cos_out = neg_reg ? 32'(-x_reg) : 32'(x_reg);
    assign sin_out = neg_reg ? 32'(-y_reg) : 32'(y_reg);

endmodule

// ----- src/aar_divider.sv -----
// Restoring unsigned divider, one quotient bit a cycle; quotient only.
// Depends on aar_pkg.
module aar_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [aar_pkg::DIV_NW-1:0] num,
    input  logic [aar_pkg::DIV_DW-1:0] den,
    output logic                       done,
    output logic [aar_pkg::DIV_NW-1:0] quot
);
    import aar_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic [DIV_NW-1:0] n_reg;
    logic [DIV_DW-1:0] rem_reg, den_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg, done_reg;
    logic [DIV_DW:0]   trial;
    logic              qbit;
    logic [DIV_DW-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, n_reg[DIV_NW-1]};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[DIV_NW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = n_reg;

endmodule

// ----- src/ackermann_arc_rollout_top.sv -----
// Top level of the steering-arc rollout: sequencer, shared multiplier, config registers.
// Depends on aar_pkg, aar_cordic and aar_divider.
//
// Usage
//   Config: write cfg_data to register cfg_index (0 count, 1 horizon, 2 speed,
//   3 time step, 4 wheelbase) when cfg_valid is high; cfg_ready is always high.
//   Write only while busy is low.
//   Request: a word is taken when start is high and busy is low; candidate_index
//   picks the steering candidate. busy stays high until the arc is finished.
//   Results: one word per Euler step on pos_x/pos_y/steer_angle/point_index,
//   marked by result_valid for one cycle; last_point flags the final one.
//   The receiver cannot stall; every strobed word must be taken.
//   An index at or beyond the candidate count gives one word with bad_index
//   and last_point set, in the cycle after the request, without going busy.
// Sequence
//   Arc setup: three divides (steering angle, tan, heading rate), one CORDIC pass,
//   two products and a reciprocal wrap of the heading rate to 2*pi in ST_MOD_RCP,
//   ST_MOD_QC and ST_MOD_FIX; a single candidate skips the angle divide.
//   Each point: one CORDIC pass plus the two products and the update.
//   The one divider serves all three divides; the one CORDIC serves setup and points.
// Reset: config registers return to their defaults, the sequencer goes idle.
module ackermann_arc_rollout_top #(
    parameter int MAX_STEPS      = 64,
    parameter int MAX_CANDIDATES = 64,
    parameter int CORDIC_ITERS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [5:0]         candidate_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    output logic               result_valid,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [13:0] steer_angle,
    output logic [5:0]         point_index,
    output logic               last_point,
    output logic               bad_index
);
    import aar_pkg::*;

    localparam int STEP_CAP = (MAX_STEPS < 64) ? MAX_STEPS : 64;

    typedef enum logic [17:0] {
        ST_IDLE      = 18'b00_0000_0000_0000_0001,
        ST_ANG_DIV   = 18'b00_0000_0000_0000_0010,
        ST_ANG_WAIT  = 18'b00_0000_0000_0000_0100,
        ST_SC        = 18'b00_0000_0000_0000_1000,
        ST_SC_WAIT   = 18'b00_0000_0000_0001_0000,
        ST_TAN_DIV   = 18'b00_0000_0000_0010_0000,
        ST_TAN_WAIT  = 18'b00_0000_0000_0100_0000,
        ST_MUL_NUM   = 18'b00_0000_0000_1000_0000,
        ST_MUL_H     = 18'b00_0000_0001_0000_0000,
        ST_H_DIV     = 18'b00_0000_0010_0000_0000,
        ST_H_WAIT    = 18'b00_0000_0100_0000_0000,
        ST_MOD_RCP   = 18'b00_0000_1000_0000_0000,
        ST_MOD_QC    = 18'b00_0001_0000_0000_0000,
        ST_MOD_FIX   = 18'b00_0010_0000_0000_0000,
        ST_STEP      = 18'b00_0100_0000_0000_0000,
        ST_STEP_WAIT = 18'b00_1000_0000_0000_0000,
        ST_MUL_X     = 18'b01_0000_0000_0000_0000,
        ST_MUL_Y     = 18'b10_0000_0000_0000_0000
    } state_t;

    // per-point update: x in ST_MUL_Y, y, heading and outputs in the emit cycle after it
    state_t state_reg, state_next;
    logic   emit_reg, emit_next;

    // configuration
    logic [6:0]  cc_reg, hs_reg;
    logic [19:0] speed_reg;
    logic [15:0] dt_reg, wb_reg;

    // arc working state
    logic [5:0]         k_reg;
    logic [6:0]         kc_reg, n_reg;
    logic signed [13:0] delta_reg;
    logic               tneg_reg;
    logic [19:0]        mag_reg;
    logic [20:0]        vdt_reg;
    logic [16:0]        dh_reg, theta_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [5:0]         step_reg;

    // shared multiplier
    logic signed [36:0] mul_a;
    logic signed [21:0] mul_b;
    mul_prod_t          mul_p_reg;

    // units
    logic              cor_start, cor_done;
    ang_q30_t          cor_angle;
    trig_t             cor_cos, cor_sin;
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den;

    logic [6:0]         kc_new, n_new;
    logic               accept;
    logic [30:0]        c_cl;
    logic [31:0]        s_abs;
    logic [15:0]        wb_eff;
    logic signed [17:0] head_ang;
    logic [17:0]        theta_sum;
    logic [19:0]        mod_r1;
    logic [16:0]        h_mod;
    logic signed [31:0] x_step;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE) || emit_reg;
    assign cfg_ready = 1'b1;
    assign wb_eff    = (wb_reg == 16'd0) ? 16'd1 : wb_reg;

    assign kc_new = ({25'd0, cc_reg} > MAX_CANDIDATES) ? 7'(MAX_CANDIDATES) : cc_reg;
    assign n_new  = ({25'd0, hs_reg} > STEP_CAP) ? 7'(STEP_CAP) : hs_reg;

    // cos clamped to at least 1, |sin|
    assign c_cl  = (cor_cos < 32'sd1) ? 31'd1 : cor_cos[30:0];
    assign s_abs = cor_sin[31] ? 32'(-cor_sin) : 32'(cor_sin);

    // heading mapped to [-pi, pi)
    assign head_ang = (theta_reg >= PI_Q14) ?
                      $signed({1'b0, theta_reg}) - $signed({1'b0, TWO_PI_Q14}) :
                      $signed({1'b0, theta_reg});
    assign theta_sum = {1'b0, theta_reg} + {1'b0, dh_reg};

    // heading rate minus estimated quotient times 2*pi; estimate is short by at most one
    assign mod_r1 = div_quot[19:0] - mul_p_reg[19:0];
    assign h_mod  = (mod_r1 >= 20'(TWO_PI_Q14)) ?
                    17'(mod_r1 - 20'(TWO_PI_Q14)) : mod_r1[16:0];
    assign x_step = round_q30(mul_p_reg);

    aar_cordic #(
        .ITERS(CORDIC_ITERS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .angle  (cor_angle),
        .done   (cor_done),
        .cos_out(cor_cos),
        .sin_out(cor_sin)
    );

    aar_divider u_divider (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quot (div_quot)
    );

    // unit launches and operand selection
    always_comb
    begin
        cor_start = 1'b0;
        cor_angle = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_ANG_DIV:
            begin
                div_start = 1'b1;
                div_num   = 64'(k_reg) * 64'(STEER_SPAN2) + 64'(kc_reg - 7'd1);
                div_den   = 40'(kc_reg - 7'd1) << 1;
            end
            ST_SC:
            begin
                cor_start = 1'b1;
                cor_angle = {{4{delta_reg[13]}}, delta_reg, 16'd0};
            end
            ST_TAN_DIV:
            begin
                div_start = 1'b1;
                div_num   = (64'(s_abs) << 20) + 64'(c_cl >> 1);
                div_den   = 40'(c_cl);
            end
            ST_MUL_NUM:
            begin
                mul_a = $signed(37'(speed_reg));
                mul_b = $signed(22'(dt_reg));
            end
            ST_MUL_H:
            begin
                // speed * dt from ST_MUL_NUM is in the product register now
                mul_a = $signed({1'b0, mul_p_reg[35:0]});
                mul_b = $signed({2'b00, mag_reg});
            end
            ST_H_DIV:
            begin
                div_start = 1'b1;
                div_num   = 64'(mul_p_reg) + (64'(wb_eff) << 21);
                div_den   = 40'(wb_eff) << 22;
            end
            ST_MOD_RCP:
            begin
                // heading rate stays below 2^35
                mul_a = $signed({2'b00, div_quot[34:0]});
                mul_b = $signed({1'b0, MOD_RECIP});
            end
            ST_MOD_QC:
            begin
                mul_a = $signed(37'(mul_p_reg[57:37]));
                mul_b = $signed({5'd0, TWO_PI_Q14});
            end
            ST_STEP:
            begin
                cor_start = 1'b1;
                cor_angle = {head_ang, 16'd0};
            end
            ST_MUL_X:
            begin
                mul_a = 37'(cor_cos);
                mul_b = $signed({1'b0, vdt_reg});
            end
            ST_MUL_Y:
            begin
                mul_a = 37'(cor_sin);
                mul_b = $signed({1'b0, vdt_reg});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        emit_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (emit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (accept && ({1'b0, candidate_index} < kc_new) && (n_new != 7'd0))
                begin
                    state_next = (kc_new == 7'd1) ? ST_SC : ST_ANG_DIV;
                end
            end
            ST_ANG_DIV:   state_next = ST_ANG_WAIT;
            ST_ANG_WAIT:  if (div_done) state_next = ST_SC;
            ST_SC:        state_next = ST_SC_WAIT;
            ST_SC_WAIT:   if (cor_done) state_next = ST_TAN_DIV;
            ST_TAN_DIV:   state_next = ST_TAN_WAIT;
            ST_TAN_WAIT:  if (div_done) state_next = ST_MUL_NUM;
            ST_MUL_NUM:   state_next = ST_MUL_H;
            ST_MUL_H:     state_next = ST_H_DIV;
            ST_H_DIV:     state_next = ST_H_WAIT;
            ST_H_WAIT:    if (div_done) state_next = ST_MOD_RCP;
            ST_MOD_RCP:   state_next = ST_MOD_QC;
            ST_MOD_QC:    state_next = ST_MOD_FIX;
            ST_MOD_FIX:   state_next = ST_STEP;
            ST_STEP:      state_next = ST_STEP_WAIT;
            ST_STEP_WAIT: if (cor_done) state_next = ST_MUL_X;
            ST_MUL_X:     state_next = ST_MUL_Y;
            ST_MUL_Y:
            begin
                emit_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
        // point emit cycle: carry on with the next step unless this was the last
        if (emit_reg && ({1'b0, step_reg} != n_reg - 7'd1))
        begin
            state_next = ST_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            emit_reg     <= 1'b0;
            result_valid <= 1'b0;
            cc_reg       <= 7'd11;
            hs_reg       <= 7'd10;
            speed_reg    <= 20'd32768;
            dt_reg       <= 16'd6554;
            wb_reg       <= 16'd10813;
        end
        else
        begin
            state_reg    <= state_next;
            emit_reg     <= emit_next;
            result_valid <= emit_reg ||
                            (accept && ({1'b0, candidate_index} >= kc_new));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAND_COUNT: cc_reg    <= cfg_data[6:0];
                    CFG_HORIZON:    hs_reg    <= cfg_data[6:0];
                    CFG_SPEED:      speed_reg <= cfg_data;
                    CFG_TIME_STEP:  dt_reg    <= cfg_data[15:0];
                    CFG_WHEELBASE:  wb_reg    <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            k_reg     <= candidate_index;
            kc_reg    <= kc_new;
            n_reg     <= n_new;
            delta_reg <= '0;
            if ({1'b0, candidate_index} >= kc_new)
            begin
                pos_x       <= '0;
                pos_y       <= '0;
                steer_angle <= '0;
                point_index <= '0;
                last_point  <= 1'b1;
                bad_index   <= 1'b1;
            end
        end
        if (state_reg == ST_ANG_WAIT && div_done)
        begin
            delta_reg <= $signed(div_quot[13:0] - STEER_LIMIT);
        end
        if (state_reg == ST_TAN_WAIT && div_done)
        begin
            mag_reg  <= div_quot[19:0];
            tneg_reg <= cor_sin[31];
        end
        if (state_reg == ST_MUL_H)
        begin
            // product of ST_MUL_NUM is ready here
            vdt_reg <= 21'((37'(mul_p_reg[35:0]) + 37'd32768) >> 16);
        end
        if (state_reg == ST_MOD_FIX)
        begin
            dh_reg    <= (tneg_reg && h_mod != 17'd0) ? TWO_PI_Q14 - h_mod : h_mod;
            theta_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            step_reg  <= '0;
        end
        if (state_reg == ST_MUL_Y)
        begin
            x_reg <= x_reg + x_step;
        end
        if (emit_reg)
        begin
            y_reg       <= y_reg + x_step;
            pos_x       <= x_reg;
            pos_y       <= y_reg + x_step;
            steer_angle <= delta_reg;
            point_index <= step_reg;
            last_point  <= ({1'b0, step_reg} == n_reg - 7'd1);
            bad_index   <= 1'b0;
            theta_reg   <= (theta_sum >= {1'b0, TWO_PI_Q14}) ?
                           17'(theta_sum - {1'b0, TWO_PI_Q14}) : theta_sum[16:0];
            step_reg    <= step_reg + 6'd1;
        end
    end

`ifndef SYNTHESIS
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bad_index |-> last_point)
        else $error("bad-index word without last_point");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_point |-> busy)
        else $error("arc dropped before its last point");

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_point |-> state_reg == ST_IDLE)
        else $error("sequencer still running after last point");

    a_point_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !bad_index |-> {1'b0, point_index} < n_reg)
        else $error("point index beyond horizon");
`endif

endmodule

// ----- tb/tb_ackermann_arc_rollout_top.sv -----
// Self-checking testbench for ackermann_arc_rollout_top: a queue-fed request driver,
// a result monitor and a bit-accurate arc predictor. Depends on aar_pkg and the RTL.
module tb_ackermann_arc_rollout_top;
    timeunit 1ns;
    timeprecision 1ps;
    import aar_pkg::*;

    localparam int  STEPS_CAP    = 64;
    localparam int  CAND_CAP     = 64;
    localparam int  ITERS        = 16;
    localparam int  WATCHDOG_MAX = 20000;
    localparam int  SETTLE_CYC   = 40;
    localparam longint STEER_LIM_L = 5734;
    localparam longint TWO_PI_L    = 102944;
    localparam longint PI_L        = 51472;
    localparam longint PI30_L      = 64'sd3373259426;
    localparam longint HPI30_L     = 64'sd1686629713;
    localparam longint GAIN30_L    = 64'sd652032875;
    localparam longint ONE30_L     = 64'sd1073741824;

    // arctan(2^-i) in Q.30, first ITERS entries
    localparam longint ATAN_TAB [ITERS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768
    };

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [13:0] steer;
        logic [5:0]         step;
        logic               last;
        logic               bad;
    } arc_point_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [5:0]         candidate_index = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [19:0]        cfg_data = '0;
    logic               result_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [13:0] steer_angle;
    logic [5:0]         point_index;
    logic               last_point;
    logic               bad_index;

    // Shadow copy of the config registers, reset values
    logic [6:0]  sh_count   = 7'd11;
    logic [6:0]  sh_horizon = 7'd10;
    logic [19:0] sh_speed   = 20'd32768;
    logic [15:0] sh_dt      = 16'd6554;
    logic [15:0] sh_wbase   = 16'd10813;

    logic [5:0]  pending_req_q [$];
    arc_point_t  expected_pts_q [$];
    int          send_idle_pct = 0;
    int          mismatches = 0;
    int          requests_taken = 0;
    int          points_seen = 0;
    int          bad_seen = 0;
    int          quiet_cycles = 0;

    ackermann_arc_rollout_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .candidate_index (candidate_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .steer_angle     (steer_angle),
        .point_index     (point_index),
        .last_point      (last_point),
        .bad_index       (bad_index)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Arc predictor
    // ---------------------------------------------------------------

    // Rotation-mode CORDIC, gain pre-applied; folds by pi outside +-pi/2
    task automatic cordic_sincos(input longint ang, output longint c, output longint s);
        longint xa, ya, za, dx, dy;
        bit     flip;
        xa   = GAIN30_L;
        ya   = 0;
        flip = 1'b0;
        if (ang > HPI30_L) begin
            ang  = ang - PI30_L;
            flip = 1'b1;
        end
        else if (ang < -HPI30_L) begin
            ang  = ang + PI30_L;
            flip = 1'b1;
        end
        za = ang;
        for (int i = 0; i < ITERS; i++) begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (za >= 0) begin
                xa = xa - dx;
                ya = ya + dy;
                za = za - ATAN_TAB[i];
            end
            else begin
                xa = xa + dx;
                ya = ya - dy;
                za = za + ATAN_TAB[i];
            end
        end
        c = flip ? -xa : xa;
        s = flip ? -ya : ya;
    endtask

    // round half away from zero, d > 0
    function automatic longint div_round(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    // Works out every point of the arc for candidate k under the current registers
    task automatic predict_arc(input logic [5:0] k);
        longint unsigned cand, nsteps, wb, num, mag, den, hrate, vdt, prod;
        longint     delta, c, s, tan20, dh, xa, ya, theta, ang, co, si, tmag;
        arc_point_t pt;
        cand   = (sh_count > CAND_CAP) ? CAND_CAP : sh_count;
        nsteps = (sh_horizon > STEPS_CAP) ? STEPS_CAP : sh_horizon;
        wb     = (sh_wbase == 0) ? 1 : sh_wbase;
        if (k >= cand) begin
            pt = '{x: '0, y: '0, steer: '0, step: '0, last: 1'b1, bad: 1'b1};
            expected_pts_q.insert(expected_pts_q.size(), pt);
            return;
        end
        if (nsteps == 0)
            return;
        if (cand == 1)
            delta = 0;
        else begin
            prod  = k * 2 * STEER_LIM_L;
            delta = -STEER_LIM_L + longint'((2 * prod + (cand - 1)) / (2 * (cand - 1)));
        end
        cordic_sincos(delta * 65536, c, s);
        if (c < 1)
            c = 1;
        tmag  = ((s < 0 ? -s : s) * 1048576 + c / 2) / c;
        tan20 = (s < 0) ? -tmag : tmag;
        num   = sh_speed * sh_dt;
        mag   = (tan20 < 0) ? -tan20 : tan20;
        den   = wb << 22;
        hrate = ((num * mag + den / 2) / den) % TWO_PI_L;
        if (tan20 < 0)
            hrate = (TWO_PI_L - hrate) % TWO_PI_L;
        dh    = longint'(hrate);
        vdt   = (num + 32768) >> 16;
        xa    = 0;
        ya    = 0;
        theta = 0;
        for (int st = 0; st < nsteps; st++) begin
            ang = (theta >= PI_L) ? theta - TWO_PI_L : theta;
            cordic_sincos(ang * 65536, co, si);
            xa       = xa + div_round(longint'(vdt) * co, ONE30_L);
            ya       = ya + div_round(longint'(vdt) * si, ONE30_L);
            theta    = (theta + dh) % TWO_PI_L;
            pt.x     = xa[31:0];
            pt.y     = ya[31:0];
            pt.steer = delta[13:0];
            pt.step  = st[5:0];
            pt.last  = (st + 1 == nsteps);
            pt.bad   = 1'b0;
            expected_pts_q.insert(expected_pts_q.size(), pt);
        end
    endtask

    // ---------------------------------------------------------------
    // Request driver: holds start until busy drops, idles at random
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start           <= 1'b0;
            candidate_index <= '0;
        end
        else begin
            if (start && !busy) begin
                // word taken at this edge; registers cannot change under it
                predict_arc(candidate_index);
                pending_req_q.delete(0);
                requests_taken++;
            end
            if (start && busy) begin
                // hold the word until the block frees up
            end
            else if (pending_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                start           <= 1'b1;
                candidate_index <= pending_req_q[0];
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: every strobed word is compared with the oldest point
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        arc_point_t e;
        if (rst_n && result_valid) begin
            points_seen++;
            if (bad_index)
                bad_seen++;
            if (expected_pts_q.size() == 0) begin
                $error("unexpected result word: pos_x %0d pos_y %0d", pos_x, pos_y);
                mismatches++;
            end
            else begin
                e = expected_pts_q.pop_front();
                if (pos_x !== e.x) begin
                    $error("pos_x expected %0d got %0d", e.x, pos_x);
                    mismatches++;
                end
                if (pos_y !== e.y) begin
                    $error("pos_y expected %0d got %0d", e.y, pos_y);
                    mismatches++;
                end
                if (steer_angle !== e.steer) begin
                    $error("steer_angle expected %0d got %0d", e.steer, steer_angle);
                    mismatches++;
                end
                if (point_index !== e.step) begin
                    $error("point_index expected %0d got %0d", e.step, point_index);
                    mismatches++;
                end
                if (last_point !== e.last) begin
                    $error("last_point expected %0b got %0b", e.last, last_point);
                    mismatches++;
                end
                if (bad_index !== e.bad) begin
                    $error("bad_index expected %0b got %0b", e.bad, bad_index);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any handshake counts as progress
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("watchdog expired, %0d points outstanding", expected_pts_q.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // One register write; shadow copy follows at the accepting edge
    task automatic write_reg(input cfg_index_t idx, input logic [19:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_CAND_COUNT: sh_count   = val[6:0];
            CFG_HORIZON:    sh_horizon = val[6:0];
            CFG_SPEED:      sh_speed   = val;
            CFG_TIME_STEP:  sh_dt      = val[15:0];
            CFG_WHEELBASE:  sh_wbase   = val[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Waits for every request taken, every point back and the block idle
    task automatic drain;
        while (pending_req_q.size() != 0 || expected_pts_q.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_all(input logic [6:0] cnt, input logic [6:0] hor,
                           input logic [19:0] spd, input logic [15:0] dt,
                           input logic [15:0] wb);
        write_reg(CFG_CAND_COUNT, 20'(cnt));
        write_reg(CFG_HORIZON, 20'(hor));
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_TIME_STEP, 20'(dt));
        write_reg(CFG_WHEELBASE, 20'(wb));
    endtask

    // Random register set, mostly short arcs, with candidates largely in range
    task automatic random_round(input int n_items);
        logic [6:0] cnt, hor;
        int         r;
        r   = $urandom_range(9);
        cnt = (r == 0) ? 7'd1 : (r == 1) ? 7'd64 : 7'($urandom_range(2, 64));
        r   = $urandom_range(19);
        hor = (r == 0) ? 7'd64 : (r < 4) ? 7'($urandom_range(11, 40))
                                         : 7'($urandom_range(1, 10));
        set_all(cnt, hor, 20'($urandom_range(20'hFFFFF)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)));
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(9) == 0)
                pending_req_q.insert(pending_req_q.size(), 6'($urandom_range(63)));
            else
                pending_req_q.insert(pending_req_q.size(), 6'($urandom_range(cnt - 1)));
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset settings, both ends of the index range, out-of-range index
        pending_req_q = '{6'd0, 6'd10, 6'd5, 6'd11, 6'd63};
        drain();
        // single candidate gives a straight run; second index is out of range
        set_all(7'd1, 7'd3, 20'd65536, 16'd6554, 16'd10813);
        pending_req_q = '{6'd0, 6'd1};
        drain();
        // widest spread, longest arc, tightest wheelbase
        set_all(7'd64, 7'd64, 20'hFFFFF, 16'hFFFF, 16'd1);
        pending_req_q = '{6'd0, 6'd63, 6'd31};
        drain();
        // count of zero: every index is flagged
        write_reg(CFG_CAND_COUNT, 20'd0);
        pending_req_q = '{6'd0, 6'd42};
        drain();
        // count and horizon beyond the cap, zero wheelbase, zero speed
        set_all(7'd127, 7'd127, 20'd0, 16'd1, 16'd0);
        pending_req_q = '{6'd63, 6'd21};
        drain();
        // zero time step keeps every point at the origin; widest wheelbase
        set_all(7'd2, 7'd4, 20'hFFFFF, 16'd0, 16'hFFFF);
        pending_req_q = '{6'd0, 6'd1};
        drain();
        // zero horizon: in-range indices give nothing back; index 9 is still flagged
        set_all(7'd9, 7'd0, 20'd32768, 16'd6554, 16'd10813);
        pending_req_q = '{6'd4, 6'd8};
        drain();
        pending_req_q = '{6'd9};
        drain();

        // Random: sender idle about a third of the time, then mostly idle, then never idle
        send_idle_pct = 35;
        repeat (10) random_round(7);
        send_idle_pct = 74;
        repeat (10) random_round(7);
        send_idle_pct = 0;
        repeat (10) random_round(7);

        $display("covered %0d requests, %0d result words (%0d flagged bad index)",
                 requests_taken, points_seen, bad_seen);
        $display("register extremes, clamped counts, zero wheelbase/dt/horizon exercised");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
